// ===== src/bbs_pkg.sv =====
// Package of shared constants and types for the Bollinger band signal core.
package bbs_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  localparam int PRICE_W = 32;
  localparam int WIN_W = 7;
  localparam int EDGE_W = 16;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW     = 3'd0,
    REG_USE_EMA    = 3'd1,
    REG_SHORT_SIDE = 3'd2,
    REG_OPEN_EDGE  = 3'd3,
    REG_CLOSE_EDGE = 3'd4
  } reg_idx_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [WIN_W-1:0]  window;
    logic              use_ema;
    logic              short_side;
    logic [EDGE_W-1:0] open_edge;
    logic [EDGE_W-1:0] close_edge;
  } cfg_t;

endpackage

// ===== src/bbs_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module bbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share one address; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/bbs_engine.sv =====
// Sequencer that reads the price ring and computes mean, deviation and flags.
module bbs_engine #(
  parameter int MAX_WINDOW = bbs_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bbs_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bbs_pkg::PRICE_W-1:0] in_price,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbs_pkg::PRICE_W+bbs_pkg::PRICE_W+2:0] out_word
);

  localparam int PRICE_BITS = bbs_pkg::PRICE_BITS_DEF;
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = PRICE_BITS + CW;
  localparam int QW = 2 * PRICE_BITS + CW;
  localparam int RW = PRICE_BITS + 1;
  localparam int EDGE_W_L = bbs_pkg::EDGE_W;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WINDOW);

  typedef enum logic [3:0] {
    S_IDLE, S_EMA_DIV, S_SUM_RD, S_SUM_ACC, S_MEAN_DIV, S_SQ_RD, S_SQ_ACC,
    S_SQ_DIV, S_ROOT, S_MUL, S_FLAGS, S_OUT
  } state_t;

  state_t state_r;
  logic [AW-1:0] wslot_r, rd_r, ram_addr;
  logic [CW-1:0] fill_r, steps_r, wlen_r, cnt_r;
  logic [PRICE_BITS-1:0] price_r, ema_r, mean_r;
  logic [SW-1:0] sum_r;
  logic [QW-1:0] sq_r;
  logic [QW-1:0] num_r, quo_r;
  logic [QW:0] rem_r;
  logic [7:0] bit_r;
  logic [RW-1:0] sd_r;
  logic [2*RW-1:0] rad_r;
  logic [2*RW+1:0] rrem_r;
  logic [RW+EDGE_W_L-1:0] offo_r, offc_r;
  logic [PRICE_BITS-1:0] ram_rd;
  logic ram_we;
  logic [PRICE_BITS-1:0] d_abs;
  logic [2*PRICE_BITS-1:0] d_sq;
  logic [CW-1:0] w_cl;
  logic rdy_r, open_r, close_r;
  logic [RW+EDGE_W_L-1:0] offo_w, offc_w;
  logic [PRICE_BITS-1:0] mid;
  logic [PRICE_BITS-1:0] gap;
  logic [QW:0] rem_sh;
  logic [2*RW+1:0] trial;
  logic [2*RW+1:0] rrem_sh;

  // Ring slot before the given one, wrapping at the ring depth.
  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] a);
    return (a == '0) ? AW'(MAX_WINDOW - 1) : a - AW'(1);
  endfunction

  // Clamp the window register into its legal range.
  always_comb begin
    if (cfg.window < 7'd2) begin
      w_cl = CW'(2);
    end else if (int'(cfg.window) > MAX_WINDOW) begin
      w_cl = MAXW;
    end else begin
      w_cl = CW'(cfg.window);
    end
  end

  // Ring address: write slot at entry, then the read pointer walking back.
  assign ram_we = (state_r == S_IDLE) && in_valid;
  assign ram_addr = (state_r == S_IDLE) ? wslot_r : rd_r;

  bbs_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(in_price[PRICE_BITS-1:0]), .rdata(ram_rd)
  );

  assign d_abs = (ram_rd > mean_r) ? ram_rd - mean_r : mean_r - ram_rd;
  assign d_sq = (2*PRICE_BITS)'(d_abs) * (2*PRICE_BITS)'(d_abs);
  assign mid = cfg.use_ema ? ema_r : mean_r;
  assign gap = (price_r > mid) ? price_r - mid : mid - price_r;
  assign rem_sh = {rem_r[QW-1:0], num_r[QW-1]};
  assign rrem_sh = {rrem_r[2*RW-1:0], rad_r[2*RW-1:2*RW-2]};
  assign trial = (2*RW+2)'({sd_r, 2'b01});
  assign offo_w = offo_r >> 8;
  assign offc_w = offc_r >> 8;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Main sequencer: one divide/root step per cycle in the division and root states; both band multiplies in S_MUL.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wslot_r <= '0;
      fill_r <= '0;
      steps_r <= '0;
      ema_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            price_r <= in_price[PRICE_BITS-1:0];
            rd_r <= wslot_r;
            wslot_r <= (wslot_r == AW'(MAX_WINDOW - 1)) ? '0 : wslot_r + AW'(1);
            if (fill_r < MAXW) fill_r <= fill_r + CW'(1);
            wlen_r <= w_cl;
            if (steps_r == '0) begin
              ema_r <= in_price[PRICE_BITS-1:0];
              steps_r <= CW'(1);
              state_r <= S_SUM_RD;
            end else begin
              logic [CW-1:0] n;
              n = (steps_r < w_cl) ? steps_r + CW'(1) : w_cl;
              steps_r <= n;
              num_r <= QW'(n - CW'(1)) * QW'(ema_r) +
                       QW'({in_price[PRICE_BITS-1:0], 1'b0});
              state_r <= S_EMA_DIV;
            end
            rem_r <= '0;
            bit_r <= 8'(QW);
            cnt_r <= '0;
            sum_r <= '0;
          end
        end
        S_EMA_DIV: begin
          if (rem_sh >= (QW+1)'(steps_r) + (QW+1)'(1)) begin
            rem_r <= rem_sh - ((QW+1)'(steps_r) + (QW+1)'(1));
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          num_r <= num_r << 1;
          bit_r <= bit_r - 8'd1;
          if (bit_r == 8'd1) state_r <= S_SUM_RD;
        end
        S_SUM_RD: begin
          if (bit_r == 8'd0 && steps_r != CW'(1)) ema_r <= quo_r[PRICE_BITS-1:0];
          bit_r <= 8'hFF;
          rd_r <= prev_slot(rd_r);
          rdy_r <= (fill_r >= wlen_r);
          if (fill_r >= wlen_r) begin
            state_r <= S_SUM_ACC;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_SUM_ACC: begin
          sum_r <= sum_r + SW'(ram_rd);
          rd_r <= prev_slot(rd_r);
          if (cnt_r == wlen_r - CW'(1)) begin
            num_r <= QW'(sum_r + SW'(ram_rd));
            rem_r <= '0;
            bit_r <= 8'(QW);
            state_r <= S_MEAN_DIV;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_MEAN_DIV: begin
          if (rem_sh >= (QW+1)'(wlen_r)) begin
            rem_r <= rem_sh - (QW+1)'(wlen_r);
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          num_r <= num_r << 1;
          bit_r <= bit_r - 8'd1;
          if (bit_r == 8'd1) begin
            cnt_r <= '0;
            sq_r <= '0;
            rd_r <= prev_slot(wslot_r);
            state_r <= S_SQ_RD;
          end
        end
        S_SQ_RD: begin
          mean_r <= quo_r[PRICE_BITS-1:0];
          rd_r <= prev_slot(rd_r);
          state_r <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          sq_r <= sq_r + QW'(d_sq);
          rd_r <= prev_slot(rd_r);
          if (cnt_r == wlen_r - CW'(1)) begin
            num_r <= sq_r + QW'(d_sq);
            rem_r <= '0;
            bit_r <= 8'(QW);
            state_r <= S_SQ_DIV;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_SQ_DIV: begin
          if (rem_sh >= (QW+1)'(wlen_r)) begin
            rem_r <= rem_sh - (QW+1)'(wlen_r);
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          num_r <= num_r << 1;
          if (bit_r == 8'd1) begin
            sd_r <= '0;
            rrem_r <= '0;
            bit_r <= 8'(RW);
            state_r <= S_ROOT;
          end else begin
            bit_r <= bit_r - 8'd1;
          end
        end
        S_ROOT: begin
          if (bit_r == 8'(RW)) rad_r <= (2*RW)'(quo_r);
          else begin
            if (rrem_sh >= trial) begin
              rrem_r <= rrem_sh - trial;
              sd_r <= {sd_r[RW-2:0], 1'b1};
            end else begin
              rrem_r <= rrem_sh;
              sd_r <= {sd_r[RW-2:0], 1'b0};
            end
            rad_r <= rad_r << 2;
          end
          bit_r <= bit_r - 8'd1;
          if (bit_r == 8'd0) state_r <= S_MUL;
        end
        S_MUL: begin
          offo_r <= (RW+EDGE_W_L)'(sd_r) * (RW+EDGE_W_L)'(cfg.open_edge);
          offc_r <= (RW+EDGE_W_L)'(sd_r) * (RW+EDGE_W_L)'(cfg.close_edge);
          state_r <= S_FLAGS;
        end
        S_FLAGS: begin
          if (!cfg.short_side) begin
            open_r <= price_r > mid && (RW+EDGE_W_L)'(gap) < offo_w;
            close_r <= (price_r > mid && (RW+EDGE_W_L)'(gap) > offc_w) ||
                       (price_r < mid && (RW+EDGE_W_L)'(gap) > offo_w);
          end else begin
            open_r <= price_r < mid && (RW+EDGE_W_L)'(gap) < offo_w;
            close_r <= (price_r < mid && (RW+EDGE_W_L)'(gap) > offc_w) ||
                       (price_r > mid && (RW+EDGE_W_L)'(gap) > offo_w);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result word: ready, middle line, deviation, open, close.
  always_comb begin
    logic [bbs_pkg::PRICE_W-1:0] sd_o;
    sd_o = (sd_r > RW'({bbs_pkg::PRICE_W{1'b1}})) ? '1 : bbs_pkg::PRICE_W'(sd_r);
    if (rdy_r) begin
      out_word = {close_r, open_r, sd_o, bbs_pkg::PRICE_W'(mid), 1'b1};
    end else begin
      out_word = '0;
    end
  end

endmodule

// ===== src/bollinger_band_signal_core.sv =====
// Top level of the Bollinger band signal core: configuration registers and engine.
// Each price word is accepted only when the core is idle; it is written into a
// ring RAM and one result word follows; no new price is taken until that word
// is taken. Once the window is full, an item goes through two sequential
// passes over the ring RAM (one read a cycle), three restoring divisions of 71
// one-bit steps, a square root of 33 one-bit steps and the entry, setup, band
// multiply, flags and output steps. While the window is still filling, an item
// takes the EMA division and its control states; the first price after reset
// skips the division. No clearing pass follows reset.
module bollinger_band_signal_core #(
  parameter int MAX_WINDOW = bbs_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // price
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // ready_res, middle_line, deviation, open, close
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bbs_pkg::cfg_t cfg_r;
  logic [bbs_pkg::PRICE_W-1:0] price_m;
  logic [2*bbs_pkg::PRICE_W+2:0] word;

  assign cfg_ready = 1'b1;

  // Register file writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window <= 7'd2;
      cfg_r.use_ema <= 1'b0;
      cfg_r.short_side <= 1'b0;
      cfg_r.open_edge <= 16'd128;
      cfg_r.close_edge <= 16'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bbs_pkg::REG_WINDOW:     cfg_r.window <= cfg_data[6:0];
        bbs_pkg::REG_USE_EMA:    cfg_r.use_ema <= cfg_data[0];
        bbs_pkg::REG_SHORT_SIDE: cfg_r.short_side <= cfg_data[0];
        bbs_pkg::REG_OPEN_EDGE:  cfg_r.open_edge <= cfg_data;
        bbs_pkg::REG_CLOSE_EDGE: cfg_r.close_edge <= cfg_data;
        default: ;
      endcase
    end
  end

  assign price_m = in_tdata &
                   bbs_pkg::PRICE_W'((64'd1 << bbs_pkg::PRICE_BITS_DEF) - 64'd1);

  bbs_engine #(.MAX_WINDOW(MAX_WINDOW)) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_price(price_m),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_word(word)
  );

  assign out_tdata = {5'd0, word};

endmodule

// ===== src/bbs_checker.sv =====
// Port checker for the Bollinger band signal core, bound to the top level.
module bbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // A result word holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // No input is taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while result pending");

  // An accepted word never shows its result next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result too early");

  // Not-ready results carry zero fields.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[66:1] == 66'd0)
    else $error("non-zero fields while not ready");

endmodule

bind bollinger_band_signal_core bbs_checker u_bbs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== bench/bollinger_band_signal_core_tb.sv =====
// Self-checking testbench for the Bollinger band signal core: price words in, band words out.
module bollinger_band_signal_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Result word fields, highest bit first.
  typedef struct packed {
    logic        close_s;
    logic        open_s;
    logic [31:0] sd;
    logic [31:0] mid;
    logic        rdy;
  } band_word_t;

  // Predicts each band word from the price history and checks the block's words.
  class band_scoreboard;
    logic [31:0] prices[64];
    int unsigned slot, filled, ema_n;
    logic [63:0] ema;
    int unsigned win;
    bit ema_mid, short_dir;
    logic [15:0] edge_open, edge_close;
    band_word_t pending[$];
    int errors;

    function new();
      win = 2; ema_mid = 0; short_dir = 0; edge_open = 128; edge_close = 512;
      slot = 0; filled = 0; ema_n = 0; ema = 0; errors = 0;
    endfunction

    function void set_reg(bbs_pkg::reg_idx_t idx, logic [15:0] v);
      case (idx)
        bbs_pkg::REG_WINDOW: win = v[6:0];
        bbs_pkg::REG_USE_EMA: ema_mid = v[0];
        bbs_pkg::REG_SHORT_SIDE: short_dir = v[0];
        bbs_pkg::REG_OPEN_EDGE: edge_open = v;
        bbs_pkg::REG_CLOSE_EDGE: edge_close = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] offset_of(logic [63:0] sd, logic [15:0] e);
      logic [127:0] prod;
      prod = sd * e;
      if (prod[127:72] != 0) return '1;
      return prod[71:8];
    endfunction

    // Notes an accepted price and queues the band word it should produce.
    function void note_price(logic [31:0] p);
      int unsigned w, i;
      logic [63:0] sum, mean, mid, sd, offo, offc, d, v;
      logic [127:0] sq, t;
      band_word_t r;
      w = win < 2 ? 2 : (win > 64 ? 64 : win);
      prices[slot] = p;
      slot = (slot + 1) % 64;
      if (filled < 64) filled++;
      if (ema_n == 0) begin
        ema = p; ema_n = 1;
      end else begin
        ema_n = ema_n < w ? ema_n + 1 : w;
        ema = ((ema_n - 1) * ema + 2 * 64'(p)) / (ema_n + 1);
      end
      r = '0;
      if (filled >= w) begin
        sum = 0;
        for (i = 0; i < w; i++) sum += prices[(slot + 63 - i) % 64];
        mean = sum / w;
        sq = 0;
        for (i = 0; i < w; i++) begin
          v = prices[(slot + 63 - i) % 64];
          d = v > mean ? v - mean : mean - v;
          sq += 128'(d) * d;
        end
        sq = sq / w;
        sd = 0;
        for (int b = 63; b >= 0; b--) begin
          t = 128'(sd | (64'd1 << b));
          if (t * t <= sq) sd = sd | (64'd1 << b);
        end
        mid = ema_mid ? ema : mean;
        offo = offset_of(sd, edge_open);
        offc = offset_of(sd, edge_close);
        if (!short_dir) begin
          r.open_s = p > mid && (p - mid) < offo;
          r.close_s = (p > mid && (p - mid) > offc) || (p < mid && (mid - p) > offo);
        end else begin
          r.open_s = p < mid && (mid - p) < offo;
          r.close_s = (p < mid && (mid - p) > offc) || (p > mid && (p - mid) > offo);
        end
        r.rdy = 1;
        r.mid = mid[31:0];
        r.sd = sd > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sd[31:0];
      end
      pending.insert(pending.size(), r);
    endfunction

    // Compares an accepted band word with the oldest expectation.
    function void check_word(band_word_t got);
      band_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.rdy !== exp_w.rdy) report("ready_res", exp_w.rdy, got.rdy);
      if (got.mid !== exp_w.mid) report("middle_line", exp_w.mid, got.mid);
      if (got.sd !== exp_w.sd) report("deviation", exp_w.sd, got.sd);
      if (got.open_s !== exp_w.open_s) report("open_signal", exp_w.open_s, got.open_s);
      if (got.close_s !== exp_w.close_s) report("close_signal", exp_w.close_s, got.close_s);
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, f, e, a);
      errors++;
    endfunction
  endclass

  localparam int LIMIT = 2_000_000;
  localparam int DRAIN = 400;
  localparam int HOLD_LEN = 3000;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [31:0] in_tdata = 0;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [71:0] out_tdata;
  int cycles = 0;
  int long_hold = 0;
  logic hold_go = 0;
  logic hold_done = 0;
  band_scoreboard sb;

  bollinger_band_signal_core dut (.*);

  always #1 clk = ~clk;

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("bollinger_band_signal_core test failed");
      $finish;
    end
  end

  // Receiver: stalls on its own pattern, with one long hold-off when asked.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(band_word_t'(out_tdata[66:0]));
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      long_hold <= HOLD_LEN;
      out_tready <= 0;
    end else if (long_hold > 0) begin
      out_tready <= 0;
      long_hold <= long_hold - 1;
    end else begin
      out_tready <= (cycles % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(bbs_pkg::reg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
  endtask

  task automatic send_price(logic [31:0] p);
    in_tvalid <= 1; in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_price(p);
  endtask

  task automatic pause_sender();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    pause_sender();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Random price around a base, sometimes anywhere in range.
  function automatic logic [31:0] rand_price(logic [31:0] base, int spread);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return base + $urandom_range(0, spread) - spread / 2;
    endcase
  endfunction

  task automatic random_phase(int n, logic [31:0] base, int spread);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_price(rand_price(base, spread));
        sent++;
      end
      if ($urandom_range(0, 1)) begin
        in_tvalid <= 0;
        repeat ($urandom_range(1, 300)) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [31:0] base;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: defaults, extremes of the price, all registers.
    send_price(32'h0);
    send_price(32'hFFFF_FFFF);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0);
    send_price(32'h8000_0000);
    send_price(32'h5555_5555);
    send_price(32'hAAAA_AAAA);
    drain();
    write_reg(bbs_pkg::REG_WINDOW, 16'd0);
    write_reg(bbs_pkg::REG_USE_EMA, 16'd1);
    write_reg(bbs_pkg::REG_SHORT_SIDE, 16'd1);
    write_reg(bbs_pkg::REG_OPEN_EDGE, 16'hFFFF);
    write_reg(bbs_pkg::REG_CLOSE_EDGE, 16'd0);
    send_price(32'h100);
    send_price(32'h300);
    send_price(32'h200);
    send_price(32'h180);
    drain();
    write_reg(bbs_pkg::REG_WINDOW, 16'd127);
    write_reg(bbs_pkg::REG_OPEN_EDGE, 16'd0);
    write_reg(bbs_pkg::REG_CLOSE_EDGE, 16'hFFFF);
    for (int i = 0; i < 10; i++) send_price(32'h1000 + i * 16);
    drain();
    write_reg(bbs_pkg::REG_WINDOW, 16'd3);
    for (int i = 0; i < 4; i++) send_price(i[0] ? 32'hFFFF_FFFF : 32'h7FFF_FFFF);
    drain();

    // Random phases over several settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(bbs_pkg::REG_WINDOW,
                ph == 0 ? 16'd64 : (ph == 1 ? 16'd2 : 16'($urandom_range(0, 70))));
      write_reg(bbs_pkg::REG_USE_EMA, 16'($urandom_range(0, 1)));
      write_reg(bbs_pkg::REG_SHORT_SIDE, 16'($urandom_range(0, 1)));
      write_reg(bbs_pkg::REG_OPEN_EDGE, 16'($urandom_range(0, 1200)));
      write_reg(bbs_pkg::REG_CLOSE_EDGE, 16'($urandom_range(0, 2400)));
      base = $urandom_range(32'h100, 32'hFFFF_0000);
      if (ph == 3) hold_go <= 1'b1;
      random_phase(75, base, ph[0] ? 4096 : 256);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bollinger_band_signal_core test passed");
    end else begin
      $display("bollinger_band_signal_core test failed");
    end
    $finish;
  end
endmodule
